[hdl/assert_macros.svh]
// Assertion macros included by the encoder top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

[hdl/ookrs_pkg.sv]
// Package: frame constants, register indexes and shared types for the OOK encoder
`timescale 1ns / 1ps
package ookrs_pkg;

  localparam int unsigned ZONE_W    = 5;
  localparam int unsigned DEV_W     = 5;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned REPEAT_W  = 8;
  localparam int unsigned CHIP_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ZONE_KEY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 2'd2;

  localparam logic [ZONE_W-1:0]   ZONE_KEY_RST     = 5'd3;
  localparam logic [TICK_W-1:0]   PULSE_TICKS_RST  = 16'd300;
  localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RST = 8'd10;

  localparam logic [7:0] CHIP_ONE_BYTE  = 8'd136;
  localparam logic [7:0] CHIP_ZERO_BYTE = 8'd142;
  localparam logic [7:0] SYNC_BYTE      = 8'd128;
  localparam logic [7:0] PAD_BYTE       = 8'd0;

  localparam logic [CHIP_W-1:0] LAST_CHIP = 7'd127;

  typedef struct packed {
    logic [ZONE_W-1:0] zone_key;
    logic [DEV_W-1:0]  device;
    logic              on;
  } frame_info_t;

endpackage

[hdl/ook_remote_switch_encoder_unit.sv]
// Top level: OOK remote-switch frame encoder with config registers and result register
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | cmd, device_mask, switch_on
//  out     | output    | out_valid/out_ready| line_level, busy_res
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: state update and chip lookup sit between the state
// registers and the result register, so an item's result is registered as the item is accepted.
// in_ready is high whenever the result register is empty or being taken.
// Synchronous reset clears the transmitter state and loads the register defaults.
// A stalled output holds its result and blocks new items only while full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ook_remote_switch_encoder_unit
  import ookrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [DEV_W-1:0]     device_mask,
  input  logic                 switch_on,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 line_level,
  output logic                 busy_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [ZONE_W-1:0]   zone_key;
  logic [TICK_W-1:0]   pulse_ticks;
  logic [REPEAT_W-1:0] repeat_count;

  logic                active,        active_next;
  logic [DEV_W-1:0]    held_device,   held_device_next;
  logic                held_on,       held_on_next;
  logic [REPEAT_W-1:0] frames_left,   frames_left_next;
  logic [CHIP_W-1:0]   chip_position, chip_position_next;
  logic [TICK_W-1:0]   tick_count,    tick_count_next;

  logic                accept;
  logic [TICK_W:0]     tick_inc;
  logic [TICK_W:0]     period;
  frame_info_t         info_next;
  logic                level_next;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_key     <= ZONE_KEY_RST;
      pulse_ticks  <= PULSE_TICKS_RST;
      repeat_count <= REPEAT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZONE_KEY:     zone_key     <= cfg_data[ZONE_W-1:0];
        REG_PULSE_TICKS:  pulse_ticks  <= cfg_data[TICK_W-1:0];
        REG_REPEAT_COUNT: repeat_count <= cfg_data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero pulse length counts as one tick
  assign period   = (pulse_ticks == '0) ? (TICK_W+1)'(1) : {1'b0, pulse_ticks};
  assign tick_inc = {1'b0, tick_count} + (TICK_W+1)'(1);

  always_comb begin
    active_next        = active;
    held_device_next   = held_device;
    held_on_next       = held_on;
    frames_left_next   = frames_left;
    chip_position_next = chip_position;
    tick_count_next    = tick_count;
    if (cmd) begin
      if (!active) begin
        active_next        = 1'b1;
        held_device_next   = device_mask;
        held_on_next       = switch_on;
        frames_left_next   = repeat_count;
        chip_position_next = '0;
        tick_count_next    = '0;
      end
    end else if (active) begin
      if (tick_inc >= period) begin
        tick_count_next = '0;
        if (chip_position == LAST_CHIP) begin
          chip_position_next = '0;
          // wrap into the next frame, or drop to idle after the last one
          if (frames_left == '0) begin
            active_next = 1'b0;
          end else begin
            frames_left_next = frames_left - REPEAT_W'(1);
          end
        end else begin
          chip_position_next = chip_position + CHIP_W'(1);
        end
      end else begin
        tick_count_next = tick_inc[TICK_W-1:0];
      end
    end
  end

  assign info_next.zone_key = zone_key;
  assign info_next.device   = held_device_next;
  assign info_next.on       = held_on_next;

  ookrs_chip_sel u_chip_sel (
    .info     (info_next),
    .active   (active_next),
    .chip_pos (chip_position_next),
    .level    (level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      held_device   <= '0;
      held_on       <= 1'b0;
      frames_left   <= '0;
      chip_position <= '0;
      tick_count    <= '0;
    end else if (accept) begin
      active        <= active_next;
      held_device   <= held_device_next;
      held_on       <= held_on_next;
      frames_left   <= frames_left_next;
      chip_position <= chip_position_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_level <= level_next;
      busy_res   <= active_next;
    end
  end

  `ASSERT_CLK(a_idle_line_low, clk, rst, (out_valid && !busy_res) |-> !line_level, "line high while idle")
  `ASSERT_CLK(a_idle_counters_clear, clk, rst, !active |-> (tick_count == '0 && chip_position == '0), "counters not clear while idle")
  `ASSERT_CLK(a_repeat_at_wrap, clk, rst, (active && $past(active) && frames_left != $past(frames_left)) |-> chip_position == '0, "frame count moved mid-frame")
  `ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, out_valid && busy_res == active, "accepted item lost or result out of step")

endmodule

[hdl/ookrs_chip_sel.sv]
// Chip lookup: frame byte for a chip position and the selected bit, MSB first
`timescale 1ns / 1ps
module ookrs_chip_sel
  import ookrs_pkg::*;
(
  input  frame_info_t       info,
  input  logic              active,
  input  logic [CHIP_W-1:0] chip_pos,
  output logic              level
);

  logic [3:0] byte_idx;
  logic [2:0] bit_idx;
  logic [7:0] frame_byte;

  assign byte_idx = chip_pos[6:3];
  assign bit_idx  = 3'd7 - chip_pos[2:0];

  always_comb begin
    case (byte_idx)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: begin
        frame_byte = info.zone_key[byte_idx[2:0]] ? CHIP_ONE_BYTE : CHIP_ZERO_BYTE;
      end
      4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
        frame_byte = info.device[3'(byte_idx - 4'd5)] ? CHIP_ONE_BYTE : CHIP_ZERO_BYTE;
      end
      4'd10: frame_byte = info.on ? CHIP_ONE_BYTE : CHIP_ZERO_BYTE;
      4'd11: frame_byte = info.on ? CHIP_ZERO_BYTE : CHIP_ONE_BYTE;
      4'd12: frame_byte = SYNC_BYTE;
      default: frame_byte = PAD_BYTE;
    endcase
  end

  // idle line stays low
  assign level = active & frame_byte[bit_idx];

endmodule

[dv/tb.sv]
// Testbench for the OOK remote-switch encoder: random traffic checked against a frame predictor
`timescale 1ns / 1ps
module tb;
  import ookrs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic             start;
    logic [DEV_W-1:0] dev;
    logic             turn_on;
  } remote_cmd_t;

  typedef struct packed {
    logic level;
    logic busy;
  } line_state_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 cmd;
  logic [DEV_W-1:0]     device_mask;
  logic                 switch_on;
  logic                 out_valid;
  logic                 out_ready;
  logic                 line_level;
  logic                 busy_res;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  ook_remote_switch_encoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .device_mask(device_mask),
    .switch_on  (switch_on),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_level (line_level),
    .busy_res   (busy_res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Encoder shadow: register copies and transmitter state
  logic [ZONE_W-1:0]   zone_cfg;
  logic [TICK_W-1:0]   pulse_cfg;
  logic [REPEAT_W-1:0] repeat_cfg;
  logic                tx_active;
  logic [DEV_W-1:0]    tx_dev;
  logic                tx_on;
  logic [REPEAT_W-1:0] tx_frames;
  logic [CHIP_W-1:0]   tx_chip;
  logic [TICK_W-1:0]   tx_ticks;

  remote_cmd_t cmd_q[$];
  line_state_t line_q[$];
  int          cmds_queued;
  int          cmds_taken;
  int          fail_count;
  int          cycle_count;
  bit          in_fire;
  bit          out_fire;
  int          in_gap;
  int          out_gap;
  bit          in_idle_en;
  bit          out_idle_en;

  function automatic logic frame_line();
    logic [7:0] pattern;
    logic [3:0] byte_idx;
    if (!tx_active) return 1'b0;
    byte_idx = tx_chip[6:3];
    if (byte_idx < 4'd5) begin
      pattern = zone_cfg[byte_idx[2:0]] ? CHIP_ONE_BYTE : CHIP_ZERO_BYTE;
    end else if (byte_idx < 4'd10) begin
      pattern = tx_dev[3'(byte_idx - 4'd5)] ? CHIP_ONE_BYTE : CHIP_ZERO_BYTE;
    end else if (byte_idx == 4'd10) begin
      pattern = tx_on ? CHIP_ONE_BYTE : CHIP_ZERO_BYTE;
    end else if (byte_idx == 4'd11) begin
      pattern = tx_on ? CHIP_ZERO_BYTE : CHIP_ONE_BYTE;
    end else if (byte_idx == 4'd12) begin
      pattern = SYNC_BYTE;
    end else begin
      pattern = PAD_BYTE;
    end
    // chips go out MSB first
    return pattern[3'd7 - tx_chip[2:0]];
  endfunction

  function automatic line_state_t encode_cmd(input remote_cmd_t c);
    line_state_t       r;
    logic [TICK_W:0]   next_cnt;
    logic [TICK_W-1:0] period;
    if (c.start) begin
      if (!tx_active) begin
        tx_active = 1'b1;
        tx_dev    = c.dev;
        tx_on     = c.turn_on;
        tx_frames = repeat_cfg;
        tx_chip   = '0;
        tx_ticks  = '0;
      end
    end else if (tx_active) begin
      period   = (pulse_cfg == '0) ? TICK_W'(1) : pulse_cfg;
      next_cnt = {1'b0, tx_ticks} + 1'b1;
      if (next_cnt >= {1'b0, period}) begin
        tx_ticks = '0;
        if (tx_chip == LAST_CHIP) begin
          tx_chip = '0;
          if (tx_frames == '0) tx_active = 1'b0;
          else tx_frames = tx_frames - 1'b1;
        end else begin
          tx_chip = tx_chip + 1'b1;
        end
      end else begin
        tx_ticks = next_cnt[TICK_W-1:0];
      end
    end
    r.level = frame_line();
    r.busy  = tx_active;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Acceptance on both channels, prediction and checking
  always @(posedge clk) begin : watch
    line_state_t want;
    remote_cmd_t c;
    in_fire  = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    if (out_fire) begin
      if (line_q.size() == 0) begin
        $error("result with no item pending: line_level %0b busy_res %0b", line_level, busy_res);
        fail_count++;
      end else begin
        want = line_q.pop_front();
        if (line_level !== want.level) begin
          $error("line_level: expected %0b, got %0b", want.level, line_level);
          fail_count++;
        end
        if (busy_res !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, busy_res);
          fail_count++;
        end
      end
    end
    if (in_fire) begin
      c.start   = cmd;
      c.dev     = device_mask;
      c.turn_on = switch_on;
      line_q.push_back(encode_cmd(c));
      cmds_taken++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** ook_remote_switch_encoder_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_in
    remote_cmd_t c;
    // hold the item until it is taken
    if (!rst && !(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (in_idle_en && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_valid    <= 1'b1;
        cmd         <= c.start;
        device_mask <= c.dev;
        switch_on   <= c.turn_on;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_out
    if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ready <= 1'b0;
    end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_cmd(input logic start, input logic [DEV_W-1:0] dev, input logic turn_on);
    remote_cmd_t c;
    c.start   = start;
    c.dev     = dev;
    c.turn_on = turn_on;
    cmd_q.push_back(c);
    cmds_queued++;
  endtask

  // Mostly ticks; starts while busy act as noise
  task automatic push_random(input int count, input int start_pct);
    repeat (count) begin
      push_cmd($urandom_range(0, 99) < start_pct, DEV_W'($urandom_range(0, 31)),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (cmds_taken != cmds_queued || line_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_ZONE_KEY:     zone_cfg   = val[ZONE_W-1:0];
      REG_PULSE_TICKS:  pulse_cfg  = val[TICK_W-1:0];
      REG_REPEAT_COUNT: repeat_cfg = val[REPEAT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = 1'b0;
    device_mask = '0;
    switch_on   = 1'b0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    zone_cfg    = ZONE_KEY_RST;
    pulse_cfg   = PULSE_TICKS_RST;
    repeat_cfg  = REPEAT_COUNT_RST;
    tx_active   = 1'b0;
    tx_dev      = '0;
    tx_on       = 1'b0;
    tx_frames   = '0;
    tx_chip     = '0;
    tx_ticks    = '0;
    cmds_queued = 0;
    cmds_taken  = 0;
    fail_count  = 0;
    cycle_count = 0;
    in_fire     = 1'b0;
    out_fire    = 1'b0;
    in_gap      = 0;
    out_gap     = 0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ticks while idle keep the line low
    push_cmd(1'b0, 5'h1f, 1'b1);
    push_cmd(1'b0, 5'h00, 1'b0);
    wait_drained();
    write_reg(REG_REPEAT_COUNT, 16'd1);

    // start at reset zone and pulse length; second start is ignored while busy
    push_cmd(1'b1, 5'b10101, 1'b1);
    push_cmd(1'b1, 5'h00, 1'b0);
    push_cmd(1'b0, 5'h0a, 1'b0);
    push_cmd(1'b0, 5'h15, 1'b1);
    push_cmd(1'b0, 5'h1f, 1'b0);
    wait_drained();

    // zero pulse length acts as one, and it lands below the running tick count
    write_reg(REG_PULSE_TICKS, 16'd0);
    write_reg(REG_ZONE_KEY, 16'd31);
    repeat (10) push_cmd(1'b0, DEV_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    push_cmd(1'b1, 5'h1f, 1'b1);
    wait_drained();

    write_reg(REG_PULSE_TICKS, 16'd1);
    write_reg(REG_ZONE_KEY, CFG_DAT_W'($urandom_range(0, 31)));
    write_reg(REG_REPEAT_COUNT, 16'd0);
    push_random(250, 12);
    wait_drained();

    // longest pulse and most repeats: keep the block busy so nothing latches 255 frames
    write_reg(REG_ZONE_KEY, 16'd0);
    write_reg(REG_PULSE_TICKS, 16'hffff);
    if (!tx_active) push_cmd(1'b1, DEV_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    wait_drained();
    write_reg(REG_REPEAT_COUNT, 16'd255);
    in_idle_en = 1'b0;
    push_random(25, 20);
    wait_drained();

    write_reg(REG_PULSE_TICKS, 16'd1);
    write_reg(REG_REPEAT_COUNT, 16'd2);
    write_reg(REG_ZONE_KEY, CFG_DAT_W'($urandom_range(0, 31)));
    in_idle_en  = 1'b1;
    out_idle_en = 1'b0;
    push_random(160, 10);
    wait_drained();

    write_reg(REG_PULSE_TICKS, 16'd0);
    write_reg(REG_REPEAT_COUNT, CFG_DAT_W'($urandom_range(0, 1)));
    write_reg(REG_ZONE_KEY, CFG_DAT_W'($urandom_range(0, 31)));
    out_idle_en = 1'b1;
    push_random(150, 12);
    wait_drained();

    // closing stretch runs back to back on both sides
    write_reg(REG_PULSE_TICKS, 16'd1);
    write_reg(REG_REPEAT_COUNT, 16'd0);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    push_random(120, 12);
    wait_drained();

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("** ook_remote_switch_encoder_unit: PASSED **");
    end else begin
      $display("** ook_remote_switch_encoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
